// ===== rtl/core/mscc_pkg.sv =====
`default_nettype none
package mscc_pkg;

  // default parameter values
  localparam int unsigned MAX_GRID_DIM_DEF  = 4096;
  localparam int unsigned FRACTION_BITS_DEF = 16;

  // configuration register indexes
  localparam logic [1:0] CFG_ORIGIN_X = 2'd0;
  localparam logic [1:0] CFG_ORIGIN_Y = 2'd1;
  localparam logic [1:0] CFG_STEP_X   = 2'd2;
  localparam logic [1:0] CFG_STEP_Y   = 2'd3;

  // edge codes
  localparam logic [1:0] EDGE_BOTTOM = 2'd0;
  localparam logic [1:0] EDGE_RIGHT  = 2'd1;
  localparam logic [1:0] EDGE_TOP    = 2'd2;
  localparam logic [1:0] EDGE_LEFT   = 2'd3;

  // special case codes
  localparam logic [3:0] CASE_EMPTY    = 4'd0;
  localparam logic [3:0] CASE_SADDLE_A = 4'd5;
  localparam logic [3:0] CASE_SADDLE_B = 4'd10;
  localparam logic [3:0] CASE_FULL     = 4'd15;

  // crossed edges per case code
  localparam logic [1:0] EDGE_FIRST [16] = '{
    EDGE_BOTTOM, EDGE_LEFT, EDGE_BOTTOM, EDGE_LEFT, EDGE_RIGHT, EDGE_LEFT, EDGE_BOTTOM,
    EDGE_LEFT, EDGE_TOP, EDGE_BOTTOM, EDGE_BOTTOM, EDGE_RIGHT, EDGE_RIGHT, EDGE_BOTTOM,
    EDGE_BOTTOM, EDGE_BOTTOM};
  localparam logic [1:0] EDGE_SECOND [16] = '{
    EDGE_BOTTOM, EDGE_BOTTOM, EDGE_RIGHT, EDGE_RIGHT, EDGE_TOP, EDGE_BOTTOM, EDGE_TOP,
    EDGE_TOP, EDGE_LEFT, EDGE_TOP, EDGE_RIGHT, EDGE_TOP, EDGE_LEFT, EDGE_RIGHT,
    EDGE_LEFT, EDGE_BOTTOM};

  typedef struct packed {
    logic signed [15:0] bottom_left_value;
    logic signed [15:0] bottom_right_value;
    logic signed [15:0] top_right_value;
    logic signed [15:0] top_left_value;
    logic signed [15:0] level;
    logic [11:0]        cell_column;
    logic [11:0]        cell_row;
  } in_t;

  typedef struct packed {
    logic               has_segment;
    logic signed [31:0] start_x;
    logic signed [31:0] start_y;
    logic signed [31:0] end_x;
    logic signed [31:0] end_y;
  } out_t;

endpackage
`default_nettype wire

// ===== rtl/core/marching_squares_contour_cell.sv =====
// FRACTION_BITS + 6 register stages from the input register to the output register
// throughput: one cell per cycle while the output is not stalled, set by the
//   pipelined restoring divider (one quotient bit per stage, both edges in parallel)
// a stalled output holds the whole pipeline in place
// reset (synchronous, rst_n low) clears all valid bits and loads the
//   configuration defaults: origin 0, step 1.0
`default_nettype none
module marching_squares_contour_cell #(
  parameter int unsigned MAX_GRID_DIM  = mscc_pkg::MAX_GRID_DIM_DEF,
  parameter int unsigned FRACTION_BITS = mscc_pkg::FRACTION_BITS_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_stall,
  input  wire mscc_pkg::in_t  in_data,
  output logic                out_valid,
  input  wire logic           out_stall,
  output mscc_pkg::out_t      out_data,
  input  wire logic           cfg_we,
  input  wire logic [1:0]     cfg_index,
  input  wire logic [31:0]    cfg_data
);

  localparam int QW = FRACTION_BITS + 1;   // quotient bits
  localparam int NW = 16 + QW;             // rounded dividend bits
  localparam int GW = 43;                  // index times step
  localparam int CW = 48;                  // wide coordinate
  localparam int PW = 31 + QW;             // step times fraction

  typedef struct packed {
    logic             none;
    logic [1:0]       e0;
    logic [1:0]       e1;
    logic             dz0;
    logic             dz1;
    logic signed [CW-1:0] x0;
    logic signed [CW-1:0] y0;
  } side_t;

  typedef struct packed {
    logic [15:0]   r;
    logic [QW-1:0] l;
    logic [QW-1:0] q;
    logic [15:0]   d;
  } div_t;

  // configuration registers
  logic signed [31:0] origin_x_r, origin_y_r;
  logic [30:0]        step_x_r, step_y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_x_r <= '0;
      origin_y_r <= '0;
      step_x_r   <= 31'd65536;
      step_y_r   <= 31'd65536;
    end else if (cfg_we) begin
      unique case (cfg_index)
        mscc_pkg::CFG_ORIGIN_X: origin_x_r <= cfg_data;
        mscc_pkg::CFG_ORIGIN_Y: origin_y_r <= cfg_data;
        mscc_pkg::CFG_STEP_X:   step_x_r   <= cfg_data[30:0];
        mscc_pkg::CFG_STEP_Y:   step_y_r   <= cfg_data[30:0];
      endcase
    end
  end

  // whole pipeline moves unless the output holds a stalled result
  logic adv;
  logic out_valid_r;
  assign adv      = !(out_valid_r && out_stall);
  assign in_stall = !adv;

  // stage a: input register
  logic          a_vld_r;
  mscc_pkg::in_t a_r;

  always_ff @(posedge clk) begin
    if (!rst_n) a_vld_r <= 1'b0;
    else if (adv) a_vld_r <= in_valid;
  end
  always_ff @(posedge clk) begin
    if (adv) a_r <= in_data;
  end

  // case code, saddle choice, edge operands, index products
  function automatic logic signed [15:0] corner(input mscc_pkg::in_t c, input logic [1:0] i);
    logic signed [15:0] v;
    begin
      unique case (i)
        2'd0: v = c.bottom_left_value;
        2'd1: v = c.bottom_right_value;
        2'd2: v = c.top_right_value;
        2'd3: v = c.top_left_value;
      endcase
      return v;
    end
  endfunction

  logic [3:0]          code;
  logic signed [17:0]  csum, lvl4;
  logic                above, out_of_grid;
  logic [1:0]          ea0, ea1;
  logic [15:0]         n0, d0, n1, d1;

  function automatic logic [31:0] edge_nd(input mscc_pkg::in_t c, input logic [1:0] e);
    logic signed [16:0] nd, dd;
    logic [16:0]        na, da;
    logic [15:0]        n, d;
    begin
      nd = 17'(c.level) - 17'(corner(c, e));
      dd = 17'(corner(c, e + 2'd1)) - 17'(corner(c, e));
      na = nd[16] ? 17'(-nd) : 17'(nd);
      da = dd[16] ? 17'(-dd) : 17'(dd);
      d  = da[15:0];
      n  = (na[15:0] > d) ? d : na[15:0];
      return {n, d};
    end
  endfunction

  always_comb begin
    code[0] = a_r.bottom_left_value  >= a_r.level;
    code[1] = a_r.bottom_right_value >= a_r.level;
    code[2] = a_r.top_right_value    >= a_r.level;
    code[3] = a_r.top_left_value     >= a_r.level;
    csum = 18'(a_r.bottom_left_value) + 18'(a_r.bottom_right_value)
         + 18'(a_r.top_right_value) + 18'(a_r.top_left_value);
    lvl4 = 18'(a_r.level) <<< 2;
    above = csum >= lvl4;
    out_of_grid = ({20'd0, a_r.cell_column} > 32'(MAX_GRID_DIM - 2))
               || ({20'd0, a_r.cell_row} > 32'(MAX_GRID_DIM - 2));
    ea0 = mscc_pkg::EDGE_FIRST[code];
    ea1 = mscc_pkg::EDGE_SECOND[code];
    if (code == mscc_pkg::CASE_SADDLE_A) begin
      ea0 = above ? mscc_pkg::EDGE_BOTTOM : mscc_pkg::EDGE_LEFT;
      ea1 = above ? mscc_pkg::EDGE_RIGHT  : mscc_pkg::EDGE_BOTTOM;
    end else if (code == mscc_pkg::CASE_SADDLE_B) begin
      ea0 = above ? mscc_pkg::EDGE_RIGHT  : mscc_pkg::EDGE_BOTTOM;
      ea1 = above ? mscc_pkg::EDGE_TOP    : mscc_pkg::EDGE_RIGHT;
    end
    {n0, d0} = edge_nd(a_r, ea0);
    {n1, d1} = edge_nd(a_r, ea1);
  end

  // stage b
  logic          b_vld_r, b_none_r;
  logic [1:0]    b_e0_r, b_e1_r;
  logic [15:0]   b_n0_r, b_d0_r, b_n1_r, b_d1_r;
  logic [GW-1:0] b_px_r, b_py_r;

  always_ff @(posedge clk) begin
    if (!rst_n) b_vld_r <= 1'b0;
    else if (adv) b_vld_r <= a_vld_r;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      b_none_r <= (code == mscc_pkg::CASE_EMPTY) || (code == mscc_pkg::CASE_FULL)
                  || out_of_grid;
      b_e0_r <= ea0;
      b_e1_r <= ea1;
      b_n0_r <= n0;
      b_d0_r <= d0;
      b_n1_r <= n1;
      b_d1_r <= d1;
      b_px_r <= GW'(a_r.cell_column) * GW'(step_x_r);
      b_py_r <= GW'(a_r.cell_row) * GW'(step_y_r);
    end
  end

  // stage c: cell origin and rounded dividends
  function automatic div_t div_init(input logic [15:0] n, input logic [15:0] d);
    logic [NW-1:0] nn;
    div_t          s;
    begin
      nn  = (NW'(n) << FRACTION_BITS) + NW'(d >> 1);
      s.r = nn[NW-1:QW];
      s.l = nn[QW-1:0];
      s.q = '0;
      s.d = d;
      return s;
    end
  endfunction

  logic  c_vld_r;
  side_t c_side_r;
  div_t  c_dv0_r, c_dv1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) c_vld_r <= 1'b0;
    else if (adv) c_vld_r <= b_vld_r;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      c_side_r.none <= b_none_r;
      c_side_r.e0   <= b_e0_r;
      c_side_r.e1   <= b_e1_r;
      c_side_r.dz0  <= (b_d0_r == 16'd0);
      c_side_r.dz1  <= (b_d1_r == 16'd0);
      c_side_r.x0   <= CW'(origin_x_r) + $signed(CW'(b_px_r));
      c_side_r.y0   <= CW'(origin_y_r) + $signed(CW'(b_py_r));
      c_dv0_r <= div_init(b_n0_r, b_d0_r);
      c_dv1_r <= div_init(b_n1_r, b_d1_r);
    end
  end

  // divider: one quotient bit per stage
  function automatic div_t div_step(input div_t s);
    logic [16:0] t;
    logic        bit_q;
    div_t        o;
    begin
      t     = {s.r, s.l[QW-1]};
      bit_q = t >= {1'b0, s.d};
      o.r   = bit_q ? 16'(t - {1'b0, s.d}) : t[15:0];
      o.l   = s.l << 1;
      o.q   = {s.q[QW-2:0], bit_q};
      o.d   = s.d;
      return o;
    end
  endfunction

  logic  dv_vld_r  [QW];
  side_t dv_side_r [QW];
  div_t  dv0_r     [QW];
  div_t  dv1_r     [QW];

  for (genvar k = 0; k < QW; k++) begin : g_div
    logic  vld_in;
    side_t side_in;
    div_t  s0_in, s1_in;
    if (k == 0) begin : g_first
      assign vld_in  = c_vld_r;
      assign side_in = c_side_r;
      assign s0_in   = c_dv0_r;
      assign s1_in   = c_dv1_r;
    end else begin : g_next
      assign vld_in  = dv_vld_r[k-1];
      assign side_in = dv_side_r[k-1];
      assign s0_in   = dv0_r[k-1];
      assign s1_in   = dv1_r[k-1];
    end
    always_ff @(posedge clk) begin
      if (!rst_n) dv_vld_r[k] <= 1'b0;
      else if (adv) dv_vld_r[k] <= vld_in;
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        dv_side_r[k] <= side_in;
        dv0_r[k]     <= div_step(s0_in);
        dv1_r[k]     <= div_step(s1_in);
      end
    end
  end

  // stage m: step times fraction
  function automatic logic [30:0] edge_step(input logic [1:0] e, input logic [30:0] sx,
                                            input logic [30:0] sy);
    return (e == mscc_pkg::EDGE_BOTTOM || e == mscc_pkg::EDGE_TOP) ? sx : sy;
  endfunction

  logic          m_vld_r;
  side_t         m_side_r;
  logic [PW-1:0] m_p0_r, m_p1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) m_vld_r <= 1'b0;
    else if (adv) m_vld_r <= dv_vld_r[QW-1];
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      m_side_r <= dv_side_r[QW-1];
      m_p0_r <= dv_side_r[QW-1].dz0 ? '0
              : PW'(edge_step(dv_side_r[QW-1].e0, step_x_r, step_y_r)) * PW'(dv0_r[QW-1].q);
      m_p1_r <= dv_side_r[QW-1].dz1 ? '0
              : PW'(edge_step(dv_side_r[QW-1].e1, step_x_r, step_y_r)) * PW'(dv1_r[QW-1].q);
    end
  end

  // rounding, crossing point, saturation
  function automatic logic [31:0] sat32(input logic signed [CW-1:0] v);
    logic [31:0] r;
    begin
      if (v > CW'(33'sh0_7FFF_FFFF)) r = 32'h7FFF_FFFF;
      else if (v < -CW'(33'sh0_8000_0000)) r = 32'h8000_0000;
      else r = v[31:0];
      return r;
    end
  endfunction

  function automatic logic [63:0] cross_pt(input logic [1:0] e, input logic [PW-1:0] p,
                                           input side_t s, input logic [30:0] sx,
                                           input logic [30:0] sy);
    logic [PW:0]          rnd;
    logic signed [CW-1:0] off, x1, y1, x, y;
    begin
      rnd = ({1'b0, p} + (PW+1)'(1 << (FRACTION_BITS - 1))) >> FRACTION_BITS;
      off = $signed(CW'(rnd[31:0]));
      x1  = s.x0 + $signed(CW'(sx));
      y1  = s.y0 + $signed(CW'(sy));
      unique case (e)
        mscc_pkg::EDGE_BOTTOM: begin x = s.x0 + off; y = s.y0;       end
        mscc_pkg::EDGE_RIGHT:  begin x = x1;         y = s.y0 + off; end
        mscc_pkg::EDGE_TOP:    begin x = x1 - off;   y = y1;         end
        mscc_pkg::EDGE_LEFT:   begin x = s.x0;       y = y1 - off;   end
      endcase
      return {sat32(x), sat32(y)};
    end
  endfunction

  mscc_pkg::out_t out_nxt, out_r;
  logic [63:0]    pt0, pt1;

  always_comb begin
    pt0 = cross_pt(m_side_r.e0, m_p0_r, m_side_r, step_x_r, step_y_r);
    pt1 = cross_pt(m_side_r.e1, m_p1_r, m_side_r, step_x_r, step_y_r);
    if (m_side_r.none) begin
      out_nxt = '0;
    end else begin
      out_nxt.has_segment = 1'b1;
      out_nxt.start_x     = pt0[63:32];
      out_nxt.start_y     = pt0[31:0];
      out_nxt.end_x       = pt1[63:32];
      out_nxt.end_y       = pt1[31:0];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (adv) out_valid_r <= m_vld_r;
  end
  always_ff @(posedge clk) begin
    if (adv) out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // pipeline holds still while the output is stalled
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> (a_vld_r == $past(a_vld_r)) && (c_vld_r == $past(c_vld_r))
             && (m_vld_r == $past(m_vld_r)))
    else $error("pipeline valid bits moved during stall");

  // uncrossed cells carry zero coordinates
  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_r.has_segment |->
      out_r.start_x == 0 && out_r.start_y == 0 && out_r.end_x == 0 && out_r.end_y == 0)
    else $error("coordinates set without a segment");

  // reset empties the output
  a_rst: assert property (@(posedge clk)
    !rst_n |=> !out_valid_r && !m_vld_r && !a_vld_r)
    else $error("valid bits survive reset");

endmodule
`default_nettype wire

// ===== sim/contour_checker.sv =====
`timescale 1ns / 1ps
module contour_checker (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic           in_stall,
  input  mscc_pkg::in_t  in_data,
  input  logic           out_valid,
  input  logic           out_stall,
  input  mscc_pkg::out_t out_data,
  input  logic           cfg_we,
  input  logic [1:0]     cfg_index,
  input  logic [31:0]    cfg_data,
  output int             fail_count,
  output int             pending
);

  localparam int FRAC = mscc_pkg::FRACTION_BITS_DEF;
  localparam int MAX_DIM = mscc_pkg::MAX_GRID_DIM_DEF;

  // local copy of the grid geometry registers
  logic signed [63:0] org_x, org_y;
  logic [63:0]        stp_x, stp_y;
  mscc_pkg::out_t     segment_q[$];

  assign pending = segment_q.size();

  // rounded fraction of the step where the level crosses one edge
  function automatic logic signed [63:0] edge_shift(input logic signed [63:0] va,
      input logic signed [63:0] vb, input logic signed [63:0] lvl, input logic [63:0] stp);
    logic signed [63:0] nd, dd;
    logic [63:0] n, d, tq;
    nd = lvl - va;
    dd = vb - va;
    n = nd < 0 ? -nd : nd;
    d = dd < 0 ? -dd : dd;
    if (d == 0) return 0;
    if (n > d) n = d;
    tq = ((n << FRAC) + (d >> 1)) / d;
    return (stp * tq + (64'd1 << (FRAC - 1))) >> FRAC;
  endfunction

  function automatic logic [31:0] clamp32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'h7fffffff;
    if (v < -64'sd2147483648) return 32'h80000000;
    return v[31:0];
  endfunction

  // one endpoint on a given edge
  function automatic void edge_point(input logic [1:0] e, input logic signed [63:0] v[4],
      input logic signed [63:0] lvl, input logic signed [63:0] x0, input logic signed [63:0] y0,
      output logic [31:0] px, output logic [31:0] py);
    logic signed [63:0] va, vb, x, y;
    va = v[e];
    vb = v[e + 2'd1];
    case (e)
      mscc_pkg::EDGE_BOTTOM: begin x = x0 + edge_shift(va, vb, lvl, stp_x); y = y0; end
      mscc_pkg::EDGE_RIGHT: begin x = x0 + stp_x; y = y0 + edge_shift(va, vb, lvl, stp_y); end
      mscc_pkg::EDGE_TOP: begin
        x = x0 + stp_x - edge_shift(va, vb, lvl, stp_x);
        y = y0 + stp_y;
      end
      default: begin x = x0; y = y0 + stp_y - edge_shift(va, vb, lvl, stp_y); end
    endcase
    px = clamp32(x);
    py = clamp32(y);
  endfunction

  function automatic mscc_pkg::out_t contour_segment(input mscc_pkg::in_t c);
    logic signed [63:0] v[4];
    logic signed [63:0] lvl, x0, y0;
    logic [3:0] code;
    logic [1:0] e0, e1;
    mscc_pkg::out_t r;
    r = '0;
    v[0] = 64'(c.bottom_left_value);
    v[1] = 64'(c.bottom_right_value);
    v[2] = 64'(c.top_right_value);
    v[3] = 64'(c.top_left_value);
    lvl = 64'(c.level);
    for (int i = 0; i < 4; i++) code[i] = v[i] >= lvl;
    if (code == mscc_pkg::CASE_EMPTY || code == mscc_pkg::CASE_FULL) return r;
    if (c.cell_column > MAX_DIM - 2 || c.cell_row > MAX_DIM - 2) return r;
    e0 = mscc_pkg::EDGE_FIRST[code];
    e1 = mscc_pkg::EDGE_SECOND[code];
    // saddle resolved by the corner mean
    if (code == mscc_pkg::CASE_SADDLE_A || code == mscc_pkg::CASE_SADDLE_B) begin
      if (v[0] + v[1] + v[2] + v[3] >= 4 * lvl) begin
        e0 = code == mscc_pkg::CASE_SADDLE_A ? mscc_pkg::EDGE_BOTTOM : mscc_pkg::EDGE_RIGHT;
        e1 = code == mscc_pkg::CASE_SADDLE_A ? mscc_pkg::EDGE_RIGHT : mscc_pkg::EDGE_TOP;
      end else begin
        e0 = code == mscc_pkg::CASE_SADDLE_A ? mscc_pkg::EDGE_LEFT : mscc_pkg::EDGE_BOTTOM;
        e1 = code == mscc_pkg::CASE_SADDLE_A ? mscc_pkg::EDGE_BOTTOM : mscc_pkg::EDGE_RIGHT;
      end
    end
    x0 = org_x + $signed({52'd0, c.cell_column} * stp_x);
    y0 = org_y + $signed({52'd0, c.cell_row} * stp_y);
    r.has_segment = 1'b1;
    edge_point(e0, v, lvl, x0, y0, r.start_x, r.start_y);
    edge_point(e1, v, lvl, x0, y0, r.end_x, r.end_y);
    return r;
  endfunction

  // register writes, input transfers and result checks
  always @(posedge clk) begin
    mscc_pkg::out_t want;
    if (!rst_n) begin
      org_x <= '0;
      org_y <= '0;
      stp_x <= 64'd65536;
      stp_y <= 64'd65536;
      fail_count <= 0;
      segment_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          mscc_pkg::CFG_ORIGIN_X: org_x <= 64'($signed(cfg_data));
          mscc_pkg::CFG_ORIGIN_Y: org_y <= 64'($signed(cfg_data));
          mscc_pkg::CFG_STEP_X: stp_x <= 64'(cfg_data[30:0]);
          mscc_pkg::CFG_STEP_Y: stp_y <= 64'(cfg_data[30:0]);
        endcase
      end
      if (in_valid && !in_stall) segment_q.insert(segment_q.size(), contour_segment(in_data));
      if (out_valid && !out_stall) begin
        if (segment_q.size() == 0) begin
          fail_count <= fail_count + 1;
          if (fail_count < 10) $display("unexpected result %h", out_data);
        end else begin
          want = segment_q.pop_front();
          if (want.has_segment !== out_data.has_segment || want.start_x !== out_data.start_x
              || want.start_y !== out_data.start_y || want.end_x !== out_data.end_x
              || want.end_y !== out_data.end_y) begin
            fail_count <= fail_count + 1;
            if (fail_count < 10)
              $display("mismatch: expected %0d %0d %0d %0d %0d, got %0d %0d %0d %0d %0d",
                want.has_segment, want.start_x, want.start_y, want.end_x, want.end_y,
                out_data.has_segment, out_data.start_x, out_data.start_y, out_data.end_x,
                out_data.end_y);
          end
        end
      end
    end
  end
endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
module testbench;

  logic           clk = 0;
  logic           rst_n = 0;
  logic           in_valid = 0;
  logic           in_stall;
  mscc_pkg::in_t  in_data = '0;
  logic           out_valid;
  logic           out_stall = 0;
  mscc_pkg::out_t out_data;
  logic           cfg_we = 0;
  logic [1:0]     cfg_index = mscc_pkg::CFG_ORIGIN_X;
  logic [31:0]    cfg_data = 0;
  int             fail_count, pending;
  int             send_idle = 0, recv_idle = 0;
  bit             hold_off = 0;

  always #5 clk = ~clk;

  marching_squares_contour_cell i_dut (.*);
  contour_checker i_checker (.*);

  // receiver stall, with an optional long hold-off
  always @(posedge clk) begin
    if (hold_off) out_stall <= 1'b1;
    else out_stall <= $urandom_range(99) < recv_idle;
  end

  // long hold-off at the start of the first phase without idling
  initial begin
    wait (send_idle == 45);
    wait (send_idle == 0);
    hold_off <= 1'b1;
    repeat (80) @(posedge clk);
    hold_off <= 1'b0;
  end

  // one register write; cfg_we is dropped after the last write of a group
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
  endtask

  // offer one cell, holding it until the transfer
  task automatic send_cell(input mscc_pkg::in_t c);
    while (send_idle > 0 && $urandom_range(99) < send_idle) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    in_data <= c;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic drain;
    in_valid <= 0;
    while (pending != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  function automatic mscc_pkg::in_t random_cell(input bit full_range);
    mscc_pkg::in_t c;
    logic signed [15:0] base;
    c = $bits(mscc_pkg::in_t)'({$urandom, $urandom, $urandom, $urandom});
    if (!full_range) begin
      // samples scattered round the level so most cells are crossed
      base = 16'($urandom);
      c.level = base;
      c.bottom_left_value = 16'(base + $signed(16'($urandom_range(400))) - 16'sd200);
      c.bottom_right_value = 16'(base + $signed(16'($urandom_range(400))) - 16'sd200);
      c.top_right_value = 16'(base + $signed(16'($urandom_range(400))) - 16'sd200);
      c.top_left_value = 16'(base + $signed(16'($urandom_range(400))) - 16'sd200);
      if ($urandom_range(9) != 0) begin
        c.cell_column = 12'($urandom_range(4094));
        c.cell_row = 12'($urandom_range(4094));
      end
    end
    return c;
  endfunction

  initial begin
    mscc_pkg::in_t c;
    repeat (12) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: every case code, saddles both ways, extremes
    for (int k = 0; k < 16; k++) begin
      c.level = 16'sd0;
      c.bottom_left_value = k[0] ? 16'sd100 : -16'sd37;
      c.bottom_right_value = k[1] ? 16'sd9 : -16'sd200;
      c.top_right_value = k[2] ? 16'sd50 : -16'sd1;
      c.top_left_value = k[3] ? 16'sd0 : -16'sd300;
      c.cell_column = 12'(k);
      c.cell_row = 12'(15 - k);
      send_cell(c);
    end
    c = '{16'sh7fff, -16'sh8000, 16'sh7fff, -16'sh8000, -16'sh8000, 12'd4094, 12'd4094};
    send_cell(c);
    c = '{-16'sh8000, 16'sh7fff, -16'sh8000, 16'sh7fff, 16'sh7fff, 12'd0, 12'd0};
    send_cell(c);
    c = '{16'sd5, -16'sd1, 16'sd1, -16'sd1, 16'sd0, 12'd4095, 12'd3};
    send_cell(c);
    c = '{16'sd5, -16'sd1, 16'sd1, -16'sd1, 16'sd0, 12'd3, 12'd4095};
    send_cell(c);
    c = '{-16'sh8000, 16'sh7fff, 16'sh7fff, -16'sh8000, 16'sd0, 12'hfff, 12'hfff};
    send_cell(c);
    drain();

    // settings sweep: extremes, zero step, overflow
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle = 8; recv_idle = 45; end
        1: begin send_idle = 45; recv_idle = 8; end
        default: begin send_idle = 0; recv_idle = 0; end
      endcase
      case (phase)
        0: begin
          write_reg(mscc_pkg::CFG_ORIGIN_X, 32'h7fffffff);
          write_reg(mscc_pkg::CFG_ORIGIN_Y, 32'h80000000);
          write_reg(mscc_pkg::CFG_STEP_X, 32'h7fffffff);
          write_reg(mscc_pkg::CFG_STEP_Y, 32'h0);
        end
        1: begin
          write_reg(mscc_pkg::CFG_ORIGIN_X, 32'h80000000);
          write_reg(mscc_pkg::CFG_ORIGIN_Y, 32'h7fffffff);
          write_reg(mscc_pkg::CFG_STEP_X, 32'h0);
          write_reg(mscc_pkg::CFG_STEP_Y, 32'hffffffff);
        end
        2: begin
          write_reg(mscc_pkg::CFG_ORIGIN_X, $urandom);
          write_reg(mscc_pkg::CFG_ORIGIN_Y, $urandom);
          write_reg(mscc_pkg::CFG_STEP_X, $urandom_range(200000));
          write_reg(mscc_pkg::CFG_STEP_Y, $urandom_range(200000));
        end
        default: begin
          write_reg(mscc_pkg::CFG_ORIGIN_X, -32'sd65536 * 100);
          write_reg(mscc_pkg::CFG_ORIGIN_Y, 32'd12345);
          write_reg(mscc_pkg::CFG_STEP_X, 32'd16);
          write_reg(mscc_pkg::CFG_STEP_Y, 32'd3);
        end
      endcase
      cfg_we <= 0;
      for (int n = 0; n < 100; n++) send_cell(random_cell($urandom_range(4) == 0));
      drain();
    end

    if (fail_count == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

  initial begin
    #5ms;
    $display("Simulation FAILED");
    $finish;
  end
endmodule

// ===== sim.f =====
rtl/core/mscc_pkg.sv
rtl/core/marching_squares_contour_cell.sv
sim/contour_checker.sv
sim/testbench.sv
